FILE: rtl/finnis_sinclair_pair_eval_assert.svh
// Assertion macros for the Finnis-Sinclair pair evaluator.
// Expects signals named clk and rst in the scope of use.
`ifndef FINNIS_SINCLAIR_PAIR_EVAL_ASSERT_SVH
`define FINNIS_SINCLAIR_PAIR_EVAL_ASSERT_SVH

// same-cycle implication, disabled in reset
`define FSPE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define FSPE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/fspe_pkg.sv
// Shared constants and fixed-point helpers for the Finnis-Sinclair pair evaluator.
// Q16.16 signed arithmetic with saturation; no dependencies.
package fspe_pkg;

  localparam int DIST_W    = 31;
  localparam int UNIT_W    = 18;
  localparam int VAL_W     = 32;
  localparam int CFG_IDX_W = 3;

  localparam logic signed [VAL_W-1:0] VMAX   = 32'sh7fffffff;
  localparam logic signed [VAL_W-1:0] VMIN   = 32'sh80000000;
  localparam logic signed [VAL_W-1:0] ONE_Q  = 32'sd65536;
  localparam logic signed [VAL_W-1:0] TWO_Q  = 32'sd131072;

  localparam logic [CFG_IDX_W-1:0] REG_PAIR_COEF_ZERO = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAIR_COEF_ONE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAIR_COEF_TWO  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EMBED_SCALE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DENSITY_SHAPE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PAIR_CUTOFF    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DENSITY_CUTOFF = 3'd6;

  function automatic logic signed [31:0] sat34(input logic signed [33:0] x);
    if (x[33:31] == 3'b000 || x[33:31] == 3'b111) begin
      return x[31:0];
    end
    return x[33] ? VMIN : VMAX;
  endfunction

  function automatic logic signed [31:0] add_s(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    return sat34(34'(a) + 34'(b));
  endfunction

  function automatic logic signed [31:0] sub_s(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    return sat34(34'(a) - 34'(b));
  endfunction

  // product rounded half away from zero, shifted by 16 (or 17 when extra)
  function automatic logic signed [31:0] mul_q(input logic signed [31:0] a,
                                               input logic signed [31:0] b,
                                               input logic extra);
    logic [31:0] ma;
    logic [31:0] mb;
    logic [63:0] p;
    logic [63:0] sh;
    logic        neg;
    ma  = a[31] ? 32'(-a) : 32'(a);
    mb  = b[31] ? 32'(-b) : 32'(b);
    p   = 64'(ma) * 64'(mb);
    sh  = extra ? ((p + 64'd65536) >> 17) : ((p + 64'd32768) >> 16);
    neg = a[31] ^ b[31];
    if (neg) begin
      if (sh > 64'd2147483648) begin
        return VMIN;
      end
      return 32'(64'd0 - sh);
    end
    if (sh > 64'd2147483647) begin
      return VMAX;
    end
    return 32'(sh);
  endfunction

endpackage

FILE: rtl/fspe_if.sv
// Valid/ready channel interfaces for the pair evaluator: pair input and result.
// Depends on fspe_pkg for field widths.
interface fspe_in_if;
  import fspe_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [DIST_W-1:0]        distance;
  logic signed [UNIT_W-1:0] unit_x;
  logic signed [UNIT_W-1:0] unit_y;
  logic signed [UNIT_W-1:0] unit_z;
  logic [DIST_W-1:0]        density_i;
  logic [DIST_W-1:0]        density_j;
  modport source(output valid, distance, unit_x, unit_y, unit_z, density_i, density_j,
                 input ready);
  modport sink(input valid, distance, unit_x, unit_y, unit_z, density_i, density_j,
               output ready);
endinterface

interface fspe_out_if;
  import fspe_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] pair_energy;
  logic signed [VAL_W-1:0] density_term;
  logic signed [VAL_W-1:0] embed_energy;
  logic signed [VAL_W-1:0] pair_force_x;
  logic signed [VAL_W-1:0] pair_force_y;
  logic signed [VAL_W-1:0] pair_force_z;
  logic signed [VAL_W-1:0] body_force_x;
  logic signed [VAL_W-1:0] body_force_y;
  logic signed [VAL_W-1:0] body_force_z;
  modport source(output valid, pair_energy, density_term, embed_energy, pair_force_x,
                 pair_force_y, pair_force_z, body_force_x, body_force_y, body_force_z,
                 input ready);
  modport sink(input valid, pair_energy, density_term, embed_energy, pair_force_x,
               pair_force_y, pair_force_z, body_force_x, body_force_y, body_force_z,
               output ready);
endinterface

FILE: rtl/finnis_sinclair_pair_eval.sv
// Finnis-Sinclair pair evaluator: one atom pair in, one result word out.
// Depends on fspe_pkg, fspe_if and finnis_sinclair_pair_eval_assert.svh.
//
// pair_in takes distance, unit vector and both densities; pair_out returns
// pair energy, density term, embedding energy, pair force and many-body force,
// all saturated Q16.16. cfg_write/cfg_index/cfg_data load the seven
// coefficient and cutoff registers; write them only while the pipe is empty.
//
// Throughput: one word per cycle while pair_out is not stalled. The depth comes
// from the two square roots (one result bit per stage, 24 stages plus rounding)
// followed by the reciprocal dividers (one quotient bit per stage, 25 stages
// plus rounding), then the force multiplies.
// The r/d quotient and all polynomial work run alongside.
//
// Reset clears the stage valid bits and loads the default coefficients.
// When pair_out stalls, the whole pipe holds; pair_in.ready drops only while
// the output stage holds a word that is not taken. Bubbles inside the pipe
// are not squeezed out during a stall.
`include "finnis_sinclair_pair_eval_assert.svh"

module finnis_sinclair_pair_eval (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [fspe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fspe_pkg::VAL_W-1:0]     cfg_data,
  fspe_in_if.sink                        pair_in,
  fspe_out_if.source                     pair_out
);
  import fspe_pkg::*;

  localparam int SQ_FIRST = 1;
  localparam int SQ_LAST  = 24;
  localparam int SQ_ROUND = 25;
  localparam int EMB      = 26;
  localparam int RC_FIRST = 26;
  localparam int RC_LAST  = 50;
  localparam int RC_ROUND = 51;
  localparam int INV      = 52;
  localparam int T1       = 53;
  localparam int G2       = 54;
  localparam int BM       = 55;
  localparam int LAST     = 56;
  localparam int DD_FIRST = 1;
  localparam int DD_LAST  = 17;
  localparam int DD_ROUND = 18;
  localparam int BQ       = 19;
  localparam int M3       = 20;
  localparam int DT       = 21;
  localparam int T2       = 22;

  typedef struct packed {
    logic signed [31:0] c0;
    logic signed [31:0] c1;
    logic signed [31:0] c2;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic [30:0]        pc;
    logic [30:0]        dc;
  } cfg_t;

  typedef struct packed {
    logic [30:0]        r;
    logic [2:0][17:0]   u;
    logic               in_pair;
    logic               in_dens;
    logic               rho_zero;
    logic [1:0][47:0]   sq_x;
    logic [1:0][26:0]   sq_rem;
    logic [1:0][23:0]   sq_res;
    logic [1:0][24:0]   sq_root;
    logic [1:0][24:0]   rc_rem;
    logic [1:0][24:0]   rc_q;
    logic [31:0]        dd_rem;
    logic [16:0]        dd_q;
    logic signed [31:0] rc;
    logic signed [31:0] rc2;
    logic signed [31:0] rr;
    logic signed [31:0] p1;
    logic signed [31:0] p2;
    logic signed [31:0] poly;
    logic signed [31:0] dp1;
    logic signed [31:0] dpoly;
    logic signed [31:0] tr;
    logic signed [31:0] ga;
    logic signed [31:0] gb;
    logic signed [31:0] g;
    logic signed [31:0] pe;
    logic [2:0][31:0]   pf;
    logic signed [31:0] rd;
    logic signed [31:0] rd2;
    logic signed [31:0] qd;
    logic signed [31:0] bq;
    logic signed [31:0] ob;
    logic signed [31:0] m3;
    logic signed [31:0] tw;
    logic signed [31:0] dt;
    logic signed [31:0] t2;
    logic signed [31:0] ee;
    logic signed [31:0] inv;
    logic signed [31:0] t1;
    logic signed [31:0] g2;
    logic [2:0][31:0]   bm;
    logic [2:0][31:0]   bf;
  } item_t;

  cfg_t              cfg;
  item_t             pipe [0:LAST];
  logic [LAST:0]     vld;
  logic              adv;
  logic              in_acc;
  item_t             load;

  // one stage of work; k is constant per instance, so only its slice survives
  function automatic item_t stage_fn(input int k, input item_t i, input cfg_t c);
    item_t       o;
    logic [26:0] rt;
    logic [25:0] trial;
    logic [24:0] drt;
    logic [31:0] dr32;
    logic [16:0] qr;
    logic signed [31:0] rs;
    logic signed [31:0] us;
    o  = i;
    rs = $signed({1'b0, i.r});
    for (int j = 0; j < 2; j++) begin
      if (k >= SQ_FIRST && k <= SQ_LAST) begin
        rt    = {o.sq_rem[j][24:0], o.sq_x[j][47:46]};
        trial = {o.sq_res[j], 2'b01};
        if (rt >= 27'(trial)) begin
          o.sq_rem[j] = rt - 27'(trial);
          o.sq_res[j] = {o.sq_res[j][22:0], 1'b1};
        end else begin
          o.sq_rem[j] = rt;
          o.sq_res[j] = {o.sq_res[j][22:0], 1'b0};
        end
        o.sq_x[j] = {o.sq_x[j][45:0], 2'b00};
      end
      if (k == SQ_ROUND) begin
        o.sq_root[j] = {1'b0, o.sq_res[j]} + 25'(o.sq_rem[j] > 27'(o.sq_res[j]));
      end
      // 2^32 / root, one quotient bit per stage from bit 24 down
      if (k >= RC_FIRST && k <= RC_LAST) begin
        drt = (k == RC_FIRST) ? 25'd256 : {o.rc_rem[j][23:0], 1'b0};
        if (drt >= o.sq_root[j]) begin
          o.rc_rem[j] = drt - o.sq_root[j];
          o.rc_q[j]   = {o.rc_q[j][23:0], 1'b1};
        end else begin
          o.rc_rem[j] = drt;
          o.rc_q[j]   = {o.rc_q[j][23:0], 1'b0};
        end
      end
      if (k == RC_ROUND) begin
        o.rc_q[j] = o.rc_q[j] + 25'(o.rc_rem[j] >= (o.sq_root[j] - o.rc_rem[j]));
      end
    end
    // (d-r) * 2^16 / d, quotient below 2^17
    if (k >= DD_FIRST && k <= DD_LAST) begin
      dr32 = (k == DD_FIRST) ? o.dd_rem : {o.dd_rem[30:0], 1'b0};
      if (dr32 >= {1'b0, c.dc}) begin
        o.dd_rem = dr32 - {1'b0, c.dc};
        o.dd_q   = {o.dd_q[15:0], 1'b1};
      end else begin
        o.dd_rem = dr32;
        o.dd_q   = {o.dd_q[15:0], 1'b0};
      end
    end
    if (k == DD_ROUND) begin
      qr   = o.dd_q + 17'(o.dd_rem >= ({1'b0, c.dc} - o.dd_rem));
      o.qd = (c.dc == '0) ? '0 : -$signed({15'd0, qr});
    end
    if (k == 1) begin
      o.rc2 = mul_q(o.rc, o.rc, 1'b0);
      o.rr  = mul_q(rs, rs, 1'b0);
      o.p1  = mul_q(c.c1, rs, 1'b0);
      o.dp1 = mul_q(sat34(34'(c.c2) + 34'(c.c2)), rs, 1'b0);
      o.tr  = sat34(34'(o.rc) + 34'(o.rc));
      o.rd2 = mul_q(o.rd, o.rd, 1'b0);
    end
    if (k == 2) begin
      o.p2    = mul_q(c.c2, o.rr, 1'b0);
      o.dpoly = add_s(c.c1, o.dp1);
    end
    if (k == 3) begin
      o.poly = add_s(add_s(c.c0, o.p1), o.p2);
    end
    if (k == 4) begin
      o.pe = o.in_pair ? mul_q(o.rc2, o.poly, 1'b0) : '0;
      o.ga = mul_q(o.tr, o.poly, 1'b0);
      o.gb = mul_q(o.rc2, o.dpoly, 1'b0);
    end
    if (k == 5) begin
      o.g = add_s(o.ga, o.gb);
    end
    for (int n = 0; n < 3; n++) begin
      us = 32'($signed(o.u[n]));
      if (k == 6) begin
        o.pf[n] = o.in_pair ? mul_q(o.g, us, 1'b0) : '0;
      end
      if (k == BM) begin
        o.bm[n] = mul_q(o.g2, us, 1'b0);
      end
      if (k == LAST) begin
        if (!o.in_dens) begin
          o.bf[n] = '0;
        end else if (o.rho_zero) begin
          // saturate toward the sign of -A*t2*u
          if (c.a == '0 || o.t2 == '0 || o.u[n] == '0) begin
            o.bf[n] = '0;
          end else begin
            o.bf[n] = (c.a[31] ^ o.t2[31] ^ o.u[n][17]) ? VMAX : VMIN;
          end
        end else begin
          o.bf[n] = sub_s('0, $signed(o.bm[n]));
        end
      end
    end
    if (k == BQ) begin
      o.bq = mul_q(c.b, o.qd, 1'b0);
    end
    if (k == M3) begin
      o.m3 = sat34(34'(o.bq) + 34'(o.bq) + 34'(o.bq));
      o.ob = add_s(ONE_Q, o.bq);
    end
    if (k == DT) begin
      o.tw = add_s(TWO_Q, o.m3);
      o.dt = o.in_dens ? mul_q(o.rd2, o.ob, 1'b0) : '0;
    end
    if (k == T2) begin
      o.t2 = mul_q(o.rd, o.tw, 1'b0);
    end
    if (k == EMB) begin
      o.ee = sub_s('0, mul_q(c.a, $signed({7'd0, o.sq_root[0]}), 1'b0));
    end
    if (k == INV) begin
      o.inv = add_s($signed({7'd0, o.rc_q[0]}), $signed({7'd0, o.rc_q[1]}));
    end
    if (k == T1) begin
      o.t1 = mul_q(o.inv, c.a, 1'b1);
    end
    if (k == G2) begin
      o.g2 = mul_q(o.t1, o.t2, 1'b0);
    end
    return o;
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.c0 <= 32'sd81075;
      cfg.c1 <= -32'sd23542;
      cfg.c2 <= -32'sd2527;
      cfg.a  <= 32'sd119859;
      cfg.b  <= 32'sd117965;
      cfg.pc <= 31'd222822;
      cfg.dc <= 31'd233947;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PAIR_COEF_ZERO: cfg.c0 <= $signed(cfg_data);
        REG_PAIR_COEF_ONE:  cfg.c1 <= $signed(cfg_data);
        REG_PAIR_COEF_TWO:  cfg.c2 <= $signed(cfg_data);
        REG_EMBED_SCALE:    cfg.a  <= $signed(cfg_data);
        REG_DENSITY_SHAPE:  cfg.b  <= $signed(cfg_data);
        REG_PAIR_CUTOFF:    cfg.pc <= cfg_data[30:0];
        REG_DENSITY_CUTOFF: cfg.dc <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  assign adv           = !vld[LAST] || pair_out.ready;
  assign pair_in.ready = adv;
  assign in_acc        = pair_in.valid && adv;

  always_comb begin
    load          = '0;
    load.r        = pair_in.distance;
    load.u[0]     = pair_in.unit_x;
    load.u[1]     = pair_in.unit_y;
    load.u[2]     = pair_in.unit_z;
    load.in_pair  = pair_in.distance <= cfg.pc;
    load.in_dens  = pair_in.distance <= cfg.dc;
    load.rho_zero = (pair_in.density_i == '0) || (pair_in.density_j == '0);
    load.sq_x[0]  = {1'b0, pair_in.density_i, 16'd0};
    load.sq_x[1]  = {1'b0, pair_in.density_j, 16'd0};
    load.rc       = $signed({1'b0, pair_in.distance}) - $signed({1'b0, cfg.pc});
    load.rd       = $signed({1'b0, pair_in.distance}) - $signed({1'b0, cfg.dc});
    load.dd_rem   = 32'(-load.rd);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAST-1:0], in_acc};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pipe[0] <= load;
    end
  end

  for (genvar k = 1; k <= LAST; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (adv) begin
        pipe[k] <= stage_fn(k, pipe[k-1], cfg);
      end
    end
  end

  assign pair_out.valid        = vld[LAST];
  assign pair_out.pair_energy  = pipe[LAST].pe;
  assign pair_out.density_term = pipe[LAST].dt;
  assign pair_out.embed_energy = pipe[LAST].ee;
  assign pair_out.pair_force_x = $signed(pipe[LAST].pf[0]);
  assign pair_out.pair_force_y = $signed(pipe[LAST].pf[1]);
  assign pair_out.pair_force_z = $signed(pipe[LAST].pf[2]);
  assign pair_out.body_force_x = $signed(pipe[LAST].bf[0]);
  assign pair_out.body_force_y = $signed(pipe[LAST].bf[1]);
  assign pair_out.body_force_z = $signed(pipe[LAST].bf[2]);

  `FSPE_ASSERT_NEXT(a_stall_holds, !adv, $stable(vld), "pipe moved during stall")
  `FSPE_ASSERT_NEXT(a_accept_enters, in_acc, vld[0], "accepted word not in first stage")
  `FSPE_ASSERT_NEXT(a_drain_to_out, adv && vld[LAST-1], pair_out.valid,
                    "word lost before output stage")

endmodule
